>>> hdl/mrd_pkg.sv
// ----------------------------------------------------------------------------
// mrd_pkg
// Shared constants, codes and request types of the reuse distance profiler.
// ----------------------------------------------------------------------------
package mrd_pkg;

    // Sizes
    localparam int TRACKED_WORDS = 65536;
    localparam int BINS          = 1024;
    localparam int COARSE_SHIFT  = 10;
    localparam int WORD_W        = $clog2(TRACKED_WORDS);
    localparam int BIN_W         = $clog2(BINS);
    localparam int STAMP_W       = 32;
    localparam int CNT_W         = 32;
    localparam int TAB_W         = 2;
    localparam int NUM_EXACT     = 3;
    localparam int HIST_DEPTH    = NUM_EXACT * BINS;
    localparam int HIST_AW       = $clog2(HIST_DEPTH);
    localparam int IN_W          = 72;
    localparam int OUT_W         = 160;

    // Operation codes
    localparam logic [1:0] FUNC_READ   = 2'd0;
    localparam logic [1:0] FUNC_WRITE  = 2'd1;
    localparam logic [1:0] FUNC_FINISH = 2'd2;
    localparam logic [1:0] FUNC_BINRD  = 2'd3;

    // Histogram tables (exact ones; coarse partner is table + TAB_COARSE)
    localparam logic [TAB_W-1:0] TAB_RINT   = 2'd0;
    localparam logic [TAB_W-1:0] TAB_LIFE   = 2'd1;
    localparam logic [TAB_W-1:0] TAB_USE    = 2'd2;
    localparam logic [2:0]       TAB_COARSE = 3'd3;
    localparam logic [2:0]       TAB_COUNT  = 3'd6;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STAMP,
        ST_PICK,
        ST_BIN,
        ST_UPD,
        ST_FIN_ADDR,
        ST_FIN_EVAL,
        ST_FIN_NEXT,
        ST_BINREAD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                 we;
        logic [WORD_W-1:0]    waddr;
        logic [2*STAMP_W-1:0] wdata;
        logic [WORD_W-1:0]    raddr;
    } t_stamp_req;

    typedef struct packed {
        logic               we;
        logic [HIST_AW-1:0] waddr;
        logic [CNT_W-1:0]   wdata;
        logic [HIST_AW-1:0] raddr;
    } t_hist_req;

endpackage

>>> hdl/mrd_ram.sv
// ----------------------------------------------------------------------------
// mrd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mrd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/mrd_ctrl.sv
// ----------------------------------------------------------------------------
// mrd_ctrl
// Sequencer of the profiler: stamp read-modify-write, histogram updates,
// finish sweep, bin readback and clearing pass after reset.
// ----------------------------------------------------------------------------
module mrd_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [mrd_pkg::IN_W-1:0]      i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [mrd_pkg::OUT_W-1:0]     o_m_tdata,
    output mrd_pkg::t_stamp_req           o_stamp_req,
    input  logic [2*mrd_pkg::STAMP_W-1:0] i_stamp_rdata,
    output mrd_pkg::t_hist_req            o_fine_req,
    input  logic [mrd_pkg::CNT_W-1:0]     i_fine_rdata,
    output mrd_pkg::t_hist_req            o_coarse_req,
    input  logic [mrd_pkg::CNT_W-1:0]     i_coarse_rdata
);
    import mrd_pkg::*;

    t_state r_state, n_state;
    logic [1:0]          r_func, n_func;
    logic [STAMP_W-1:0]  r_now, n_now;
    logic                r_sel, n_sel;
    logic [WORD_W-1:0]   r_word, n_word;
    logic [2:0]          r_tsel, n_tsel;
    logic [9:0]          r_bidx, n_bidx;
    logic [WORD_W-1:0]   r_idx, n_idx;
    logic                r_pass, n_pass;
    logic [STAMP_W-1:0]  r_dr, n_dr;
    logic [STAMP_W-1:0]  r_dw, n_dw;
    logic [STAMP_W-1:0]  r_life, n_life;
    logic [STAMP_W-1:0]  r_dist, n_dist;
    logic [TAB_W-1:0]    r_tab, n_tab;
    logic [HIST_AW-1:0]  r_faddr, n_faddr;
    logic [HIST_AW-1:0]  r_caddr, n_caddr;
    logic [CNT_W-1:0]    r_bin, n_bin;
    logic [CNT_W-1:0]    r_rd_tot, n_rd_tot;
    logic [CNT_W-1:0]    r_rd_new, n_rd_new;
    logic [CNT_W-1:0]    r_wr_tot, n_wr_tot;
    logic [CNT_W-1:0]    r_wr_new, n_wr_new;
    logic                r_ovalid, n_ovalid;
    logic [OUT_W-1:0]    r_odata, n_odata;

    // input fields
    logic [1:0]         in_func;
    logic [STAMP_W-1:0] in_now;
    logic               in_sel;
    logic [17:0]        in_addr;
    logic [2:0]         in_tsel;
    logic [9:0]         in_bidx;
    logic [2:0]         in_ctsel;

    // stamp data
    logic [STAMP_W-1:0] rd_stamp, wr_stamp;
    logic [STAMP_W-1:0] coarse_d;
    logic [BIN_W-1:0]   fine_bin, coarse_bin;

    assign in_func  = i_s_tdata[1:0];
    assign in_now   = i_s_tdata[33:2];
    assign in_sel   = i_s_tdata[34];
    assign in_addr  = i_s_tdata[52:35];
    assign in_tsel  = i_s_tdata[55:53];
    assign in_bidx  = i_s_tdata[65:56];
    assign in_ctsel = in_tsel - TAB_COARSE;

    assign rd_stamp = i_stamp_rdata[STAMP_W-1:0];
    assign wr_stamp = i_stamp_rdata[2*STAMP_W-1:STAMP_W];

    // saturated bin indexes of the current distance
    assign coarse_d   = r_dist >> COARSE_SHIFT;
    assign fine_bin   = (r_dist >= STAMP_W'(BINS)) ? BIN_W'(BINS - 1) : r_dist[BIN_W-1:0];
    assign coarse_bin = (coarse_d >= STAMP_W'(BINS)) ? BIN_W'(BINS - 1)
                                                     : coarse_d[BIN_W-1:0];

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
            r_rd_tot <= '0;
            r_rd_new <= '0;
            r_wr_tot <= '0;
            r_wr_new <= '0;
            r_pass   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
            r_rd_tot <= n_rd_tot;
            r_rd_new <= n_rd_new;
            r_wr_tot <= n_wr_tot;
            r_wr_new <= n_wr_new;
            r_pass   <= n_pass;
        end
        r_func  <= n_func;
        r_now   <= n_now;
        r_sel   <= n_sel;
        r_word  <= n_word;
        r_tsel  <= n_tsel;
        r_bidx  <= n_bidx;
        r_dr    <= n_dr;
        r_dw    <= n_dw;
        r_life  <= n_life;
        r_dist  <= n_dist;
        r_tab   <= n_tab;
        r_faddr <= n_faddr;
        r_caddr <= n_caddr;
        r_bin   <= n_bin;
        r_odata <= n_odata;
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_func   = r_func;
        n_now    = r_now;
        n_sel    = r_sel;
        n_word   = r_word;
        n_tsel   = r_tsel;
        n_bidx   = r_bidx;
        n_idx    = r_idx;
        n_pass   = r_pass;
        n_dr     = r_dr;
        n_dw     = r_dw;
        n_life   = r_life;
        n_dist   = r_dist;
        n_tab    = r_tab;
        n_faddr  = r_faddr;
        n_caddr  = r_caddr;
        n_bin    = r_bin;
        n_rd_tot = r_rd_tot;
        n_rd_new = r_rd_new;
        n_wr_tot = r_wr_tot;
        n_wr_new = r_wr_new;
        n_odata  = r_odata;
        n_ovalid = r_ovalid && !i_m_tready;

        o_stamp_req.we     = 1'b0;
        o_stamp_req.waddr  = r_word;
        o_stamp_req.wdata  = {wr_stamp, r_now};
        o_stamp_req.raddr  = r_word;
        o_fine_req.we      = 1'b0;
        o_fine_req.waddr   = r_faddr;
        o_fine_req.wdata   = i_fine_rdata + CNT_W'(1);
        o_fine_req.raddr   = r_faddr;
        o_coarse_req.we    = 1'b0;
        o_coarse_req.waddr = r_caddr;
        o_coarse_req.wdata = i_coarse_rdata + CNT_W'(1);
        o_coarse_req.raddr = r_caddr;

        unique case (r_state)
            // zero every stamp and bin, one entry per cycle
            ST_CLEAR: begin
                o_stamp_req.we     = 1'b1;
                o_stamp_req.waddr  = r_idx;
                o_stamp_req.wdata  = '0;
                o_fine_req.we      = (32'(r_idx) < 32'(HIST_DEPTH));
                o_fine_req.waddr   = r_idx[HIST_AW-1:0];
                o_fine_req.wdata   = '0;
                o_coarse_req.we    = (32'(r_idx) < 32'(HIST_DEPTH));
                o_coarse_req.waddr = r_idx[HIST_AW-1:0];
                o_coarse_req.wdata = '0;
                if (r_idx == WORD_W'(TRACKED_WORDS - 1)) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + WORD_W'(1);
                end
            end
            // take a word, start the stamp or bin read
            ST_IDLE: begin
                o_stamp_req.raddr  = WORD_W'(in_addr >> 2);
                o_fine_req.raddr   = {in_tsel[TAB_W-1:0], BIN_W'(in_bidx)};
                o_coarse_req.raddr = {in_ctsel[TAB_W-1:0], BIN_W'(in_bidx)};
                if (i_s_tvalid) begin
                    n_func = in_func;
                    n_now  = in_now;
                    n_sel  = in_sel;
                    n_word = WORD_W'(in_addr >> 2);
                    n_tsel = in_tsel;
                    n_bidx = in_bidx;
                    n_bin  = '0;
                    n_pass = 1'b0;
                    unique case (in_func)
                        FUNC_READ, FUNC_WRITE: n_state = ST_STAMP;
                        FUNC_FINISH: begin
                            n_idx   = '0;
                            n_state = in_sel ? ST_FIN_ADDR : ST_DONE;
                        end
                        default: n_state = ST_BINREAD;
                    endcase
                end
            end
            // stamps available: write back, count, take distances
            ST_STAMP: begin
                o_stamp_req.we = 1'b1;
                n_dr = r_now - rd_stamp;
                n_dw = r_now - wr_stamp;
                n_life = (rd_stamp > wr_stamp) ? rd_stamp - wr_stamp : '0;
                n_state = ST_DONE;
                if (r_func == FUNC_READ) begin
                    o_stamp_req.wdata = {wr_stamp, r_now};
                    if (r_sel) begin
                        n_rd_tot = r_rd_tot + CNT_W'(1);
                        if (rd_stamp == '0) begin
                            n_rd_new = r_rd_new + CNT_W'(1);
                        end
                        n_state = ST_PICK;
                    end
                end else begin
                    o_stamp_req.wdata = {r_now, rd_stamp};
                    if (r_sel) begin
                        n_wr_tot = r_wr_tot + CNT_W'(1);
                        if (wr_stamp != '0) begin
                            n_state = ST_PICK;
                        end else begin
                            n_wr_new = r_wr_new + CNT_W'(1);
                        end
                    end
                end
            end
            // choose the distance and table of this pass
            ST_PICK: begin
                if (r_func == FUNC_READ) begin
                    if (!r_pass) begin
                        n_dist = (r_dr < r_dw) ? r_dr : r_dw;
                        n_tab  = TAB_RINT;
                    end else begin
                        n_dist = r_dw;
                        n_tab  = TAB_USE;
                    end
                end else begin
                    n_dist = r_life;
                    n_tab  = TAB_LIFE;
                end
                n_state = ST_BIN;
            end
            // read both bins
            ST_BIN: begin
                n_faddr            = {r_tab, fine_bin};
                n_caddr            = {r_tab, coarse_bin};
                o_fine_req.raddr   = {r_tab, fine_bin};
                o_coarse_req.raddr = {r_tab, coarse_bin};
                n_state            = ST_UPD;
            end
            // increment both bins
            ST_UPD: begin
                o_fine_req.we   = 1'b1;
                o_coarse_req.we = 1'b1;
                if (r_func == FUNC_READ && !r_pass) begin
                    n_pass  = 1'b1;
                    n_state = ST_PICK;
                end else if (r_func == FUNC_FINISH) begin
                    n_state = ST_FIN_NEXT;
                end else begin
                    n_state = ST_DONE;
                end
            end
            // finish sweep over all words
            ST_FIN_ADDR: begin
                o_stamp_req.raddr = r_idx;
                n_state           = ST_FIN_EVAL;
            end
            ST_FIN_EVAL: begin
                n_life = rd_stamp - wr_stamp;
                if (wr_stamp != '0 && rd_stamp > wr_stamp) begin
                    n_state = ST_PICK;
                end else begin
                    n_state = ST_FIN_NEXT;
                end
            end
            ST_FIN_NEXT: begin
                if (r_idx == WORD_W'(TRACKED_WORDS - 1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx   = r_idx + WORD_W'(1);
                    n_state = ST_FIN_ADDR;
                end
            end
            // bin data available
            ST_BINREAD: begin
                if (r_tsel < TAB_COUNT && 32'(r_bidx) < 32'(BINS)) begin
                    n_bin = (r_tsel < TAB_COARSE) ? i_fine_rdata : i_coarse_rdata;
                end
                n_state = ST_DONE;
            end
            // hand the result to the output register
            ST_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_odata  = {r_wr_new, r_wr_tot, r_rd_new, r_rd_tot, r_bin};
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

>>> hdl/memory_reuse_distance_profiler_top.sv
// ----------------------------------------------------------------------------
// memory_reuse_distance_profiler_top
// Reuse distance profiler: stamp memory, two histogram memories, sequencer.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------
//  s        | in        | i_s_tvalid/o_s_tready | i_s_tdata (72 bits)
//  m        | out       | o_m_tvalid/i_m_tready | o_m_tdata (160 bits)
//
//  Bin reads and unselected accesses update no histogram; a selected write
//  makes one read-modify-write pass on the histogram memories (none while
//  the word's write stamp is zero), a selected read two. A selected finish
//  sweeps all TRACKED_WORDS stamp entries, with one pass per binned word.
//  After reset a clearing pass over the TRACKED_WORDS (65536) stamp entries
//  zeroes the memories; no word is taken meanwhile. A stalled result holds in
//  the output register while the next word is accepted.
// ----------------------------------------------------------------------------
module memory_reuse_distance_profiler_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // func[1:0], instr_count[33:2], selected[34], address[52:35],
    // table_sel[55:53], bin_index[65:56], zero pad
    input  logic [mrd_pkg::IN_W-1:0]  i_s_tdata,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // bin_count[31:0], read_total[63:32], read_new_total[95:64],
    // write_total[127:96], write_new_total[159:128]
    output logic [mrd_pkg::OUT_W-1:0] o_m_tdata
);
    import mrd_pkg::*;

    t_stamp_req           stamp_req;
    t_hist_req            fine_req, coarse_req;
    logic [2*STAMP_W-1:0] stamp_rdata;
    logic [CNT_W-1:0]     fine_rdata, coarse_rdata;

    // sequencer
    mrd_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (i_s_tvalid),
        .o_s_tready     (o_s_tready),
        .i_s_tdata      (i_s_tdata),
        .o_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .o_m_tdata      (o_m_tdata),
        .o_stamp_req    (stamp_req),
        .i_stamp_rdata  (stamp_rdata),
        .o_fine_req     (fine_req),
        .i_fine_rdata   (fine_rdata),
        .o_coarse_req   (coarse_req),
        .i_coarse_rdata (coarse_rdata)
    );

    // last write and last read stamps per word
    mrd_ram #(.WIDTH(2*STAMP_W), .DEPTH(TRACKED_WORDS)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (stamp_req.we),
        .i_waddr (stamp_req.waddr),
        .i_wdata (stamp_req.wdata),
        .i_raddr (stamp_req.raddr),
        .o_rdata (stamp_rdata)
    );

    // exact histograms
    mrd_ram #(.WIDTH(CNT_W), .DEPTH(HIST_DEPTH)) u_fine_ram (
        .i_clk   (i_clk),
        .i_we    (fine_req.we),
        .i_waddr (fine_req.waddr),
        .i_wdata (fine_req.wdata),
        .i_raddr (fine_req.raddr),
        .o_rdata (fine_rdata)
    );

    // coarse histograms
    mrd_ram #(.WIDTH(CNT_W), .DEPTH(HIST_DEPTH)) u_coarse_ram (
        .i_clk   (i_clk),
        .i_we    (coarse_req.we),
        .i_waddr (coarse_req.waddr),
        .i_wdata (coarse_req.wdata),
        .i_raddr (coarse_req.raddr),
        .o_rdata (coarse_rdata)
    );

endmodule

>>> hdl/mrd_checker.sv
// ----------------------------------------------------------------------------
// mrd_checker
// Port-level checks of the profiler, bound to the top level.
// ----------------------------------------------------------------------------
module mrd_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_tvalid,
    input logic                      o_s_tready,
    input logic [mrd_pkg::IN_W-1:0]  i_s_tdata,
    input logic                      o_m_tvalid,
    input logic                      i_m_tready,
    input logic [mrd_pkg::OUT_W-1:0] o_m_tdata
);

    // reset starts the clearing pass, no word taken
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("word accepted right after reset");

    // one word at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("accepted again in the next cycle");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind memory_reuse_distance_profiler_top mrd_checker u_mrd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

>>> verif/mrd_checker.sv
// ----------------------------------------------------------------------------
// mrd_scoreboard
// Scoreboard for the reuse distance profiler: it watches both stream channels,
// keeps its own copy of the stamps, counters and histograms, predicts the
// result word for every accepted request and compares it in order.
// ----------------------------------------------------------------------------
module mrd_scoreboard (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    // func[1:0], instr_count[33:2], selected[34], address[52:35],
    // table_sel[55:53], bin_index[65:56], zero pad
    input  logic [mrd_pkg::IN_W-1:0]  i_s_tdata,
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    // bin_count[31:0], read_total[63:32], read_new_total[95:64],
    // write_total[127:96], write_new_total[159:128]
    input  logic [mrd_pkg::OUT_W-1:0] i_m_tdata,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_checked
);
    import mrd_pkg::*;

    typedef struct packed {
        logic [CNT_W-1:0] write_new_total;
        logic [CNT_W-1:0] write_total;
        logic [CNT_W-1:0] read_new_total;
        logic [CNT_W-1:0] read_total;
        logic [CNT_W-1:0] bin_count;
    } t_totals;

    // Model state; stamps default to zero (never accessed)
    logic [STAMP_W-1:0] rd_stamp [int];
    logic [STAMP_W-1:0] wr_stamp [int];
    logic [CNT_W-1:0]   hist [6][BINS];
    logic [CNT_W-1:0]   reads, new_reads, writes, new_writes;
    t_totals            totals_q [$];

    initial begin
        o_errors  = 0;
        o_checked = 0;
        reads = '0; new_reads = '0; writes = '0; new_writes = '0;
        foreach (hist[t, b]) hist[t][b] = '0;
    end

    assign o_pending = totals_q.size();

    function automatic logic [STAMP_W-1:0] stamp_of(ref logic [STAMP_W-1:0] s [int], int w);
        return s.exists(w) ? s[w] : '0;
    endfunction

    // One count into an exact table and its coarse partner, both saturating
    task automatic tally(int t, logic [STAMP_W-1:0] d);
        logic [STAMP_W-1:0] c;
        int fine, crs;
        c    = d >> COARSE_SHIFT;
        fine = (d >= BINS) ? BINS - 1 : int'(d);
        crs  = (c >= BINS) ? BINS - 1 : int'(c);
        hist[t][fine]++;
        hist[t + TAB_COARSE][crs]++;
    endtask

    task automatic predict_totals(logic [IN_W-1:0] w);
        logic [1:0]         fn;
        logic [STAMP_W-1:0] now, rd, wr, dr, dw;
        logic               sel;
        logic [2:0]         tsel;
        logic [9:0]         bidx;
        int                 word, k;
        t_totals            exp;
        fn   = w[1:0];
        now  = w[33:2];
        sel  = w[34];
        word = int'(w[52:37]);
        tsel = w[55:53];
        bidx = w[65:56];
        exp  = '0;
        rd   = stamp_of(rd_stamp, word);
        wr   = stamp_of(wr_stamp, word);
        case (fn)
            FUNC_READ: begin
                if (sel) begin
                    dr = now - rd;
                    dw = now - wr;
                    reads++;
                    if (rd == 0) new_reads++;
                    tally(TAB_RINT, (dr < dw) ? dr : dw);
                    tally(TAB_USE, dw);
                end
                rd_stamp[word] = now;
            end
            FUNC_WRITE: begin
                if (sel) begin
                    writes++;
                    if (wr != 0) tally(TAB_LIFE, (rd > wr) ? rd - wr : '0);
                    else new_writes++;
                end
                wr_stamp[word] = now;
            end
            FUNC_FINISH: begin
                // open lifetimes: written, then read later
                if (sel && wr_stamp.first(k)) begin
                    do begin
                        if (wr_stamp[k] != 0 && stamp_of(rd_stamp, k) > wr_stamp[k])
                            tally(TAB_LIFE, stamp_of(rd_stamp, k) - wr_stamp[k]);
                    end while (wr_stamp.next(k));
                end
            end
            default: begin
                if (tsel < TAB_COUNT && bidx < BINS) exp.bin_count = hist[tsel][bidx];
            end
        endcase
        exp.read_total      = reads;
        exp.read_new_total  = new_reads;
        exp.write_total     = writes;
        exp.write_new_total = new_writes;
        totals_q.push_back(exp);
    endtask

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH result %0d %s: got %0d expected %0d", o_checked, field, got,
                 want);
        o_errors++;
    endtask

    // Input side first; a result never returns on the edge its request enters
    always @(posedge i_clk) begin
        t_totals got, want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) predict_totals(i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (totals_q.size() == 0) begin
                    $display("UNEXPECTED result word with nothing pending");
                    o_errors++;
                end else begin
                    want = totals_q.pop_front();
                    if (got.bin_count !== want.bin_count)
                        report("bin_count", got.bin_count, want.bin_count);
                    if (got.read_total !== want.read_total)
                        report("read_total", got.read_total, want.read_total);
                    if (got.read_new_total !== want.read_new_total)
                        report("read_new_total", got.read_new_total, want.read_new_total);
                    if (got.write_total !== want.write_total)
                        report("write_total", got.write_total, want.write_total);
                    if (got.write_new_total !== want.write_new_total)
                        report("write_new_total", got.write_new_total,
                               want.write_new_total);
                    o_checked++;
                end
            end
        end
    end

endmodule

>>> verif/tb_memory_reuse_distance_profiler_top.sv
// ----------------------------------------------------------------------------
// tb_memory_reuse_distance_profiler_top
// Drives request words into the profiler with random gaps and output stalls:
// a directed pass over the corner cases, then random access traces on a
// small pool of words. A separate checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_memory_reuse_distance_profiler_top;
    import mrd_pkg::*;

    localparam int IDLE_LIMIT = 1500000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [IN_W-1:0]   i_s_tdata = '0;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [OUT_W-1:0]  o_m_tdata;
    int                errors, pending, checked;
    int                n_func [4];
    logic [31:0]       now_stamp;
    logic [17:0]       addr_pool [16];
    bit                calm;
    int                idle_cycles;

    always #4 i_clk = ~i_clk;

    memory_reuse_distance_profiler_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    mrd_scoreboard chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver: random stalls, calm stretches keep ready high
    always @(negedge i_clk) begin
        if (calm) i_m_tready = 1'b1;
        else if ($urandom_range(0, 99) < 4) i_m_tready = 1'b0;
        else i_m_tready = ($urandom_range(0, 99) < 70);
    end

    // Watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired with %0d results pending", pending);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_word(logic [1:0] fn, logic [31:0] instr, logic sel,
                             logic [17:0] addr, logic [2:0] tsel, logic [9:0] bidx);
        int g;
        g = gap_len();
        repeat (g) @(negedge i_clk);
        i_s_tdata  = {6'd0, bidx, tsel, addr, sel, instr, fn};
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        n_func[fn]++;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
    endtask

    // Random trace item: mostly pool words with rising stamps
    task automatic random_word();
        int          r;
        logic [1:0]  fn;
        logic [17:0] addr;
        logic [2:0]  tsel;
        logic [9:0]  bidx;
        r = $urandom_range(0, 99);
        if (r < 70) now_stamp += $urandom_range(1, 40);
        else if (r < 92) now_stamp += $urandom_range(1000, 3000000);
        else if (r < 96) now_stamp -= $urandom_range(1, 500);
        else now_stamp = $urandom;
        r  = $urandom_range(0, 99);
        fn = (r < 44) ? FUNC_READ : (r < 80) ? FUNC_WRITE : (r < 98) ? FUNC_BINRD
                                                                    : FUNC_FINISH;
        addr = ($urandom_range(0, 9) == 0) ? 18'($urandom)
                                           : {addr_pool[$urandom_range(0, 15)][17:2],
                                              2'($urandom)};
        tsel = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(0, 5));
        bidx = ($urandom_range(0, 2) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40));
        send_word(fn, ($urandom_range(0, 49) == 0) ? 32'd0 : now_stamp,
                  (fn == FUNC_FINISH) ? 1'b0 : ($urandom_range(0, 9) != 0),
                  addr, tsel, bidx);
    endtask

    initial begin
        calm = 1'b0;
        now_stamp = 32'd100;
        foreach (addr_pool[i]) addr_pool[i] = 18'($urandom);
        addr_pool[0] = 18'h00000;
        addr_pool[1] = 18'h3FFFF;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: first accesses, stamp zero, lifetimes, saturation, bin reads
        send_word(FUNC_READ,  32'd10,          1'b1, 18'h00004, 3'd0, 10'd0);
        send_word(FUNC_WRITE, 32'd20,          1'b1, 18'h00004, 3'd0, 10'd0);
        send_word(FUNC_WRITE, 32'd25,          1'b1, 18'h00005, 3'd0, 10'd0);
        send_word(FUNC_READ,  32'd40,          1'b1, 18'h00006, 3'd0, 10'd0);
        send_word(FUNC_WRITE, 32'd55,          1'b1, 18'h00007, 3'd0, 10'd0);
        send_word(FUNC_READ,  32'd0,           1'b1, 18'h00010, 3'd0, 10'd0);
        send_word(FUNC_READ,  32'd5,           1'b1, 18'h00010, 3'd0, 10'd0);
        send_word(FUNC_WRITE, 32'd0,           1'b1, 18'h00014, 3'd0, 10'd0);
        send_word(FUNC_WRITE, 32'd60,          1'b0, 18'h3FFFF, 3'd0, 10'd0);
        send_word(FUNC_READ,  32'hFFFF_FFFF,   1'b1, 18'h3FFFC, 3'd0, 10'd0);
        send_word(FUNC_READ,  32'd30,          1'b1, 18'h00004, 3'd0, 10'd0);
        send_word(FUNC_WRITE, 32'd2000000,     1'b1, 18'h3FFFF, 3'd0, 10'd0);
        send_word(FUNC_READ,  32'd3000,        1'b0, 18'h20000, 3'd0, 10'd0);
        send_word(FUNC_FINISH, 32'd0,          1'b0, 18'h00000, 3'd0, 10'd0);
        send_word(FUNC_FINISH, 32'd0,          1'b1, 18'h00000, 3'd0, 10'd0);
        send_word(FUNC_BINRD, 32'd0,           1'b0, 18'h00000, 3'd0, 10'd1023);
        send_word(FUNC_BINRD, 32'hFFFF_FFFF,   1'b1, 18'h3FFFF, 3'd1, 10'd10);
        send_word(FUNC_BINRD, 32'd0,           1'b0, 18'h00000, 3'd3, 10'd1023);
        send_word(FUNC_BINRD, 32'd0,           1'b0, 18'h00000, 3'd4, 10'd1);
        send_word(FUNC_BINRD, 32'd0,           1'b0, 18'h00000, 3'd5, 10'd0);
        send_word(FUNC_BINRD, 32'd0,           1'b0, 18'h00000, 3'd6, 10'd0);
        send_word(FUNC_BINRD, 32'd0,           1'b0, 18'h00000, 3'd7, 10'd5);
        send_word(FUNC_BINRD, 32'd0,           1'b0, 18'h00000, 3'd2, 10'd1023);

        // Hold off until everything is back, then the random trace
        drain();
        now_stamp = 32'd5000;
        for (int i = 0; i < 800; i++) begin
            if (i % 100 == 0) calm = ($urandom_range(0, 2) == 0);
            if (i == 400) begin
                drain();
                send_word(FUNC_FINISH, now_stamp, 1'b1, 18'($urandom), 3'd0, 10'd0);
            end
            random_word();
        end

        drain();
        repeat (40) @(negedge i_clk);
        $display("Ran %0d reads, %0d writes, %0d finishes, %0d bin reads",
                 n_func[FUNC_READ], n_func[FUNC_WRITE], n_func[FUNC_FINISH],
                 n_func[FUNC_BINRD]);
        $display("Compared %0d result words, %0d mismatches", checked, errors);
        if (errors == 0 && pending == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule
